// ===== rtl/dmtt_pkg.sv =====
// Shared types and constants for the direct-mapped tagged table.
// Used by the controller, the datapath and the top level; depends on nothing.
package dmtt_pkg;

  // Fixed field widths of the access channel.
  localparam int ADDR_W  = 64;
  localparam int INST_W  = 32;
  localparam int PC_W    = 64;
  localparam int MODE_W  = 2;
  localparam int SHIFT_W = 2;

  // Reset value of the instruction shift register.
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 2'd2;

  // Access modes.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the input beat and start its table access
    logic respond;  // load the result register
    logic sweep;    // write an invalid entry at the sweep counter
  } dmtt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;    // the captured item is a clear
    logic out_free;    // the result register can take a new beat
    logic sweep_last;  // the sweep counter points at the last entry
  } dmtt_stat_t;

endpackage

// ===== rtl/dmtt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; used for the table storage.
module dmtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dmtt_ctrl.sv =====
// Controller state machine for the direct-mapped tagged table.
// Depends on dmtt_pkg for the command and status structs.
module dmtt_ctrl
  import dmtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dmtt_stat_t stat,
  output dmtt_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RESP  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.respond = 1'b1;
          state_next  = stat.is_clear ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Reset starts with a sweep that invalidates every entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/dmtt_dp.sv =====
// Datapath of the direct-mapped tagged table: index and tag, table RAM,
// hit compare, result register and clearing sweep counter.
// Depends on dmtt_pkg and dmtt_ram.
module dmtt_dp
  import dmtt_pkg::*;
#(
  parameter int ENTRIES     = 1024,
  parameter int THREAD_BITS = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SHIFT_W-1:0]  cfg_wdata,
  input  logic [MODE_W-1:0]   mode,
  input  logic [ADDR_W-1:0]   address,
  input  logic                thread,
  input  logic [INST_W-1:0]   new_inst_word,
  input  logic [PC_W-1:0]     new_pc_word,
  input  dmtt_cmd_t           cmd,
  output dmtt_stat_t          stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic [INST_W-1:0]   hit_inst_word,
  output logic [PC_W-1:0]     hit_pc_word
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LG      = $clog2(ENTRIES + 1) - 1;  // floor of log2
  localparam int TAG_W   = ADDR_W - LG;
  localparam int TSHIFT  = (LG > THREAD_BITS) ? LG - THREAD_BITS : 0;
  localparam int ENTRY_W = 2 + TAG_W + INST_W + PC_W;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  logic [SHIFT_W-1:0] shift_amt;
  logic [ADDR_W-1:0]  addr_sh;
  logic [IDX_W-1:0]   idx;
  logic [TAG_W-1:0]   tag;

  logic [MODE_W-1:0]  mode_q;
  logic [TAG_W-1:0]   tag_q;
  logic               thread_q;

  logic [IDX_W-1:0]   sweep_cnt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               rd_valid;
  logic               rd_thread;
  logic [TAG_W-1:0]   rd_tag;
  logic [INST_W-1:0]  rd_inst;
  logic [PC_W-1:0]    rd_pc;
  logic               lookup_hit;

  // Instruction shift register.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amt <= SHIFT_RESET;
    end else if (cfg_we) begin
      shift_amt <= cfg_wdata;
    end
  end

  // Set index with the thread folded into its upper bits, and the tag.
  always_comb begin
    addr_sh = address >> shift_amt;
    idx     = (addr_sh[IDX_W-1:0] ^ (IDX_W'(thread) << TSHIFT)) & IDX_MASK;
    tag     = addr_sh[ADDR_W-1:LG];
  end

  // Hold the parts of the item that the response needs.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= mode;
      tag_q    <= tag;
      thread_q <= thread;
    end
  end

  // Sweep counter walks every entry once per clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= (sweep_cnt == IDX_LAST) ? '0 : sweep_cnt + 1'b1;
    end
  end

  // Table access: a lookup reads and an update writes at capture, a sweep writes an empty entry.
  always_comb begin
    ram_we    = cmd.sweep || (cmd.capture && mode == MODE_UPDATE);
    ram_waddr = cmd.sweep ? sweep_cnt : idx;
    ram_wdata = cmd.sweep ? '0 : {1'b1, thread, tag, new_inst_word, new_pc_word};
    ram_re    = cmd.capture && mode == MODE_LOOKUP;
  end

  dmtt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Unpack the read entry and compare.
  always_comb begin
    rd_pc      = ram_rdata[PC_W-1:0];
    rd_inst    = ram_rdata[PC_W +: INST_W];
    rd_tag     = ram_rdata[PC_W+INST_W +: TAG_W];
    rd_thread  = ram_rdata[ENTRY_W-2];
    rd_valid   = ram_rdata[ENTRY_W-1];
    lookup_hit = (mode_q == MODE_LOOKUP) && rd_valid && (rd_tag == tag_q) &&
                 (rd_thread == thread_q);
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.respond) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; a miss or a non-lookup returns zeros.
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      hit           <= lookup_hit;
      hit_inst_word <= lookup_hit ? rd_inst : '0;
      hit_pc_word   <= lookup_hit ? rd_pc : '0;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.is_clear   = (mode_q == MODE_CLEAR);
    stat.out_free   = !out_valid || out_ready;
    stat.sweep_last = (sweep_cnt == IDX_LAST);
  end

endmodule

// ===== rtl/direct_mapped_tagged_table.sv =====
// Direct-mapped, thread-tagged table (branch target buffer style). One item is
// in flight at a time: a lookup or update beat is taken, the table RAM is
// accessed, and the result beat is offered once the response state finds the
// result register free and loads it; the next input beat can be taken in the
// cycle after the result register is loaded. A clear returns its result beat
// and then walks the table, invalidating one entry a cycle, before the next
// input beat is taken. After reset the same sweep runs over every entry before
// the first input beat is taken; configuration writes are taken at any time.
// Depends on dmtt_pkg, dmtt_ctrl, dmtt_dp and dmtt_ram.
module direct_mapped_tagged_table
  import dmtt_pkg::*;
#(
  parameter int ENTRIES     = 1024,
  parameter int THREAD_BITS = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  mode,
  input  logic [ADDR_W-1:0]  address,
  input  logic               thread,
  input  logic [INST_W-1:0]  new_inst_word,
  input  logic [PC_W-1:0]    new_pc_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [INST_W-1:0]  hit_inst_word,
  output logic [PC_W-1:0]    hit_pc_word
);

  dmtt_cmd_t  cmd;
  dmtt_stat_t stat;

  // Controller.
  dmtt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Datapath.
  dmtt_dp #(
    .ENTRIES    (ENTRIES),
    .THREAD_BITS(THREAD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mode         (mode),
    .address      (address),
    .thread       (thread),
    .new_inst_word(new_inst_word),
    .new_pc_word  (new_pc_word),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hit_inst_word(hit_inst_word),
    .hit_pc_word  (hit_pc_word)
  );

  // A result is never loaded over a beat that has not been taken.
  assert property (@(posedge clk) disable iff (rst) cmd.respond |-> stat.out_free)
    else $error("result register overwritten before its beat was taken");

  // Only one item is in flight: an accepted beat closes the input.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is still in flight");

  // The clearing sweep never overlaps an input beat.
  assert property (@(posedge clk) disable iff (rst) cmd.sweep |-> !in_ready && !cmd.capture)
    else $error("input accepted during the clearing sweep");

  // A loaded result is offered on the output in the next cycle.
  assert property (@(posedge clk) disable iff (rst) cmd.respond |=> out_valid)
    else $error("loaded result not offered on the output");

endmodule

// ===== dv/direct_mapped_tagged_table_test.sv =====
`timescale 1ns / 100ps
// Testbench for direct_mapped_tagged_table: directed and random lookup, update and clear beats,
// checked against a behavioral copy of the table under several instruction shift settings.
// Depends on dmtt_pkg and the direct_mapped_tagged_table RTL.
module direct_mapped_tagged_table_test;
  import dmtt_pkg::*;

  localparam int ENTRIES     = 1024;
  localparam int THREAD_BITS = 1;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int THREAD_POS  = (IDX_W > THREAD_BITS) ? IDX_W - THREAD_BITS : 0;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int POOL_DEPTH    = 32;
  localparam int DRAIN_CYCLES  = 8;
  localparam int ACCESSES_PER_SHIFT = 67;
  // Shift settings for the random phases, taken two bits at a time from the bottom.
  localparam logic [11:0] SHIFT_PLAN = {2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic              thread;
    logic [INST_W-1:0] inst_word;
    logic [PC_W-1:0]   pc_word;
  } access_t;

  typedef struct {
    logic              hit;
    logic [INST_W-1:0] inst_word;
    logic [PC_W-1:0]   pc_word;
  } lookup_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [SHIFT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode = MODE_LOOKUP;
  logic [ADDR_W-1:0]  address = '0;
  logic               thread = 1'b0;
  logic [INST_W-1:0]  new_inst_word = '0;
  logic [PC_W-1:0]    new_pc_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [INST_W-1:0]  hit_inst_word;
  logic [PC_W-1:0]    hit_pc_word;

  // Behavioral copy of the table and its shift register.
  bit                 tbl_valid [ENTRIES];
  logic [ADDR_W-1:0]  tbl_tag [ENTRIES];
  logic               tbl_thread [ENTRIES];
  logic [INST_W-1:0]  tbl_inst [ENTRIES];
  logic [PC_W-1:0]    tbl_pc [ENTRIES];
  logic [SHIFT_W-1:0] shift_amt = SHIFT_RESET;

  access_t        pending_q [$];
  lookup_result_t expected_q [$];
  logic [ADDR_W-1:0] pool_addr [$];
  logic              pool_thr [$];
  lookup_result_t want;
  int fail_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_left = 0;
  int stall_left = 0;

  direct_mapped_tagged_table #(
    .ENTRIES    (ENTRIES),
    .THREAD_BITS(THREAD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .address      (address),
    .thread       (thread),
    .new_inst_word(new_inst_word),
    .new_pc_word  (new_pc_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hit_inst_word(hit_inst_word),
    .hit_pc_word  (hit_pc_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one access to the table copy and return the result beat it should produce.
  function automatic lookup_result_t access_table(access_t a);
    lookup_result_t    r;
    logic [ADDR_W-1:0] shifted;
    logic [ADDR_W-1:0] tag;
    logic [IDX_W-1:0]  idx;
    r = '{hit: 1'b0, inst_word: '0, pc_word: '0};
    shifted = a.address >> shift_amt;
    idx = shifted[IDX_W-1:0] ^ (IDX_W'(a.thread) << THREAD_POS);
    tag = a.address >> (shift_amt + IDX_W);
    case (a.mode)
      MODE_LOOKUP: begin
        if (tbl_valid[idx] && tbl_tag[idx] == tag && tbl_thread[idx] == a.thread) begin
          r.hit = 1'b1;
          r.inst_word = tbl_inst[idx];
          r.pc_word = tbl_pc[idx];
        end
      end
      MODE_UPDATE: begin
        tbl_valid[idx] = 1'b1;
        tbl_tag[idx] = tag;
        tbl_thread[idx] = a.thread;
        tbl_inst[idx] = a.inst_word;
        tbl_pc[idx] = a.pc_word;
      end
      MODE_CLEAR: begin
        tbl_valid = '{default: 1'b0};
      end
      default: begin
        // The unused mode leaves the table alone.
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mix of fully random addresses, addresses with a random index but few distinct tags, and low ones.
  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 2))
      0: return rand64();
      1: return {2'($urandom), 48'd0, 14'($urandom)};
      default: return {32'd0, $urandom};
    endcase
  endfunction

  task automatic queue_access(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] addr, logic thr,
                              logic [INST_W-1:0] iw, logic [PC_W-1:0] pw);
    pending_q.push_back('{mode: m, address: addr, thread: thr, inst_word: iw, pc_word: pw});
  endtask

  task automatic remember_entry(logic [ADDR_W-1:0] addr, logic thr);
    pool_addr.push_back(addr);
    pool_thr.push_back(thr);
    if (pool_addr.size() > POOL_DEPTH) begin
      pool_addr.delete(0);
      pool_thr.delete(0);
    end
  endtask

  // Updates and lookups of recently written entries, with random lookups, clears and unused-mode beats mixed in.
  task automatic queue_random_access();
    int unsigned       pick;
    int unsigned       k;
    logic [ADDR_W-1:0] addr;
    logic              thr;
    pick = $urandom_range(0, 99);
    addr = rand_addr();
    thr = 1'($urandom);
    if (pick < 38 && pool_addr.size() != 0) begin
      k = $urandom_range(0, pool_addr.size() - 1);
      addr = pool_addr[k] ^ (rand64() & ((64'd1 << shift_amt) - 64'd1));
      thr = pool_thr[k];
      if ($urandom_range(0, 5) == 0) thr = ~thr;
      queue_access(MODE_LOOKUP, addr, thr, $urandom, rand64());
    end else if (pick < 64) begin
      if (pick >= 60 && pool_addr.size() != 0) begin
        k = $urandom_range(0, pool_addr.size() - 1);
        addr = pool_addr[k];
        thr = pool_thr[k];
      end
      queue_access(MODE_UPDATE, addr, thr, $urandom, rand64());
      remember_entry(addr, thr);
    end else if (pick < 93) begin
      queue_access(MODE_LOOKUP, addr, thr, $urandom, rand64());
    end else if (pick < 96) begin
      queue_access(MODE_CLEAR, addr, thr, $urandom, rand64());
      pool_addr.delete();
      pool_thr.delete();
    end else begin
      queue_access(MODE_UNUSED, addr, thr, $urandom, rand64());
    end
  endtask

  task automatic write_shift(logic [SHIFT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shift_amt = v;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(access_table(pending_q[0]));
        pending_q.delete(0);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_valid <= 1'b1;
          mode <= pending_q[0].mode;
          address <= pending_q[0].address;
          thread <= pending_q[0].thread;
          new_inst_word <= pending_q[0].inst_word;
          new_pc_word <= pending_q[0].pc_word;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 50 : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready stretches of random length, with stalls of their own length between them.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (ready_left != 0) begin
      ready_left--;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      ready_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 9);
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each result beat with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with no access outstanding", $time);
        fail_count++;
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b, actual %0b", $time, want.hit, hit);
          fail_count++;
        end
        if (hit_inst_word !== want.inst_word) begin
          $display("%0t: hit_inst_word expected %h, actual %h", $time, want.inst_word,
                   hit_inst_word);
          fail_count++;
        end
        if (hit_pc_word !== want.pc_word) begin
          $display("%0t: hit_pc_word expected %h, actual %h", $time, want.pc_word,
                   hit_pc_word);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed accesses at the reset shift: index bit 9 sits at address bit 11, tag from bit 12.
    @(negedge clk);
    queue_access(MODE_LOOKUP, 64'h0, 1'b0, '1, '1);
    queue_access(MODE_UPDATE, 64'h0, 1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_access(MODE_LOOKUP, 64'h0, 1'b0, '0, '0);
    // Address bits below the instruction shift are ignored.
    queue_access(MODE_LOOKUP, 64'h3, 1'b0, '0, '0);
    // Same index and tag reached from the other thread must miss.
    queue_access(MODE_LOOKUP, 64'h800, 1'b1, '0, '0);
    // Same index with another tag must miss.
    queue_access(MODE_LOOKUP, 64'h1000, 1'b0, '0, '0);
    queue_access(MODE_UPDATE, '1, 1'b1, 32'h0, 64'h0);
    queue_access(MODE_LOOKUP, '1, 1'b1, '0, '0);
    queue_access(MODE_LOOKUP, '1, 1'b0, '0, '0);
    // The unused mode returns zeros and changes nothing.
    queue_access(MODE_UNUSED, 64'h0, 1'b0, 32'h5A5A_5A5A, 64'hA5A5_A5A5_5A5A_5A5A);
    queue_access(MODE_LOOKUP, 64'h0, 1'b0, '0, '0);
    queue_access(MODE_UPDATE, 64'h0, 1'b0, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
    queue_access(MODE_LOOKUP, 64'h0, 1'b0, '0, '0);
    queue_access(MODE_UPDATE, 64'h40, 1'b0, 32'hA5A5_A5A5, 64'h5555_AAAA_5555_AAAA);
    queue_access(MODE_CLEAR, 64'hDEAD_BEEF_0000_1234, 1'b1, '1, '1);
    queue_access(MODE_LOOKUP, 64'h0, 1'b0, '0, '0);
    queue_access(MODE_LOOKUP, '1, 1'b1, '0, '0);
    queue_access(MODE_UPDATE, 64'h40, 1'b0, 32'hC3C3_C3C3, 64'hFEDC_BA98_7654_3210);
    queue_access(MODE_LOOKUP, 64'h40, 1'b0, '0, '0);
    wait_drained();

    // A new shift takes effect without a flush: the old entry is found through a new address.
    write_shift(2'd0);
    @(negedge clk);
    queue_access(MODE_LOOKUP, 64'h40, 1'b0, '0, '0);
    queue_access(MODE_LOOKUP, 64'h10, 1'b0, '0, '0);
    queue_access(MODE_UPDATE, 64'h8000_0000_0000_0001, 1'b1, 32'h8000_0001, 64'h1);
    queue_access(MODE_LOOKUP, 64'h8000_0000_0000_0001, 1'b1, '0, '0);
    wait_drained();

    // Random phases, one per entry of the shift plan.
    for (int p = 0; p < 6; p++) begin
      write_shift(SHIFT_PLAN[2*p +: 2]);
      @(negedge clk);
      repeat (ACCESSES_PER_SHIFT) queue_random_access();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dmtt_pkg.sv
rtl/dmtt_ram.sv
rtl/dmtt_ctrl.sv
rtl/dmtt_dp.sv
rtl/direct_mapped_tagged_table.sv
dv/direct_mapped_tagged_table_test.sv
